>>> hw/rtl/masked_byte_pattern_scanner_assert.svh
// Assertion macros shared by the checker modules of the scanner.
// Each macro samples on the rising clock edge and is disabled while reset is low.
`ifndef MASKED_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SCANNER_ASSERT_SVH

// Same-cycle implication.
`define MBPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define MBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/mbps_pkg.sv
package mbps_pkg;

    localparam int DefMaxPattern = 16;

    localparam int AddrW   = 48;
    localparam int CntW    = 48;
    localparam int LenW    = 5;
    localparam int PatW    = 64;
    localparam int MaskW   = 16;
    localparam int CfgIdxW = 3;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CfgPatLow     = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgPatHigh    = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgCareMask   = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgPatLen     = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgRegionBase = 3'd4;

    typedef logic [7:0] t_byte;

    // Signature settings seen by the window comparator.
    typedef struct packed {
        logic [LenW-1:0]   len;
        logic [MaskW-1:0]  care;
        logic [2*PatW-1:0] pat;
    } t_sig_cfg;

endpackage

>>> hw/rtl/mbps_match.sv
module mbps_match #(
    parameter int MAX_PATTERN = mbps_pkg::DefMaxPattern
) (
    input  mbps_pkg::t_sig_cfg i_sig,
    input  mbps_pkg::t_byte    i_window [MAX_PATTERN],
    output logic               o_match
);

    logic [MAX_PATTERN-1:0] w_miss;

    // Window entry k holds the byte that lines up with signature byte len-1-k.
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_lane
        localparam logic [mbps_pkg::LenW-1:0] KVal = mbps_pkg::LenW'(k);
        logic [mbps_pkg::LenW-1:0] w_idx;
        mbps_pkg::t_byte           w_sig;

        assign w_idx = i_sig.len - 5'd1 - KVal;
        assign w_sig = i_sig.pat[{w_idx[3:0], 3'b000} +: 8];
        assign w_miss[k] = (KVal < i_sig.len) && i_sig.care[w_idx[3:0]] &&
                           (i_window[k] != w_sig);
    end

    assign o_match = ~|w_miss;

endmodule

>>> hw/rtl/masked_byte_pattern_scanner.sv
// A hit is found in the compare stage and presented on o_valid from the output register when
// that register is free; otherwise it waits in the compare stage until the receiver
// takes the held hit. Throughput: one byte per cycle; the input stalls only while a hit
// waits in the output register and the next hit is ready behind it.
// Reset (synchronous, active low) clears the window, the byte count, the
// pipeline valids and the configuration registers (pattern length resets to 1).
module masked_byte_pattern_scanner #(
    parameter int MAX_PATTERN = mbps_pkg::DefMaxPattern
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [mbps_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [mbps_pkg::PatW-1:0]    i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_region_end,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [mbps_pkg::AddrW-1:0]   o_hit_address
);

    localparam logic [mbps_pkg::LenW-1:0] MaxLen = mbps_pkg::LenW'(MAX_PATTERN);

    // Configuration registers.
    logic [mbps_pkg::PatW-1:0]  r_pat_low;
    logic [mbps_pkg::PatW-1:0]  r_pat_high;
    logic [mbps_pkg::MaskW-1:0] r_care;
    logic [mbps_pkg::LenW-1:0]  r_len;
    logic [mbps_pkg::AddrW-1:0] r_base;

    // Scan state.
    mbps_pkg::t_byte           r_win [MAX_PATTERN];
    logic [mbps_pkg::CntW-1:0] r_seen;
    logic                      r_last;

    // Compare stage.
    logic                       r_a_vld;
    logic                       r_a_ge;
    logic [mbps_pkg::CntW-1:0]  r_a_off;

    // Output register.
    logic                       r_out_vld;
    logic [mbps_pkg::AddrW-1:0] r_out_addr;

    logic [mbps_pkg::LenW-1:0] w_len;
    logic [mbps_pkg::LenW-1:0] w_len_m1;
    logic [mbps_pkg::CntW-1:0] w_cnt;
    logic                      w_sat;
    logic [mbps_pkg::CntW-1:0] n_seen;
    logic [mbps_pkg::CntW-1:0] n_a_off;
    logic                      n_a_ge;
    mbps_pkg::t_sig_cfg        w_sig;
    logic                      w_match;
    logic                      w_hit;
    logic                      w_out_free;
    logic                      w_adv;
    logic                      w_acc;

    always_comb begin
        w_len    = (r_len > MaxLen) ? MaxLen : r_len;
        w_len_m1 = w_len - 5'd1;
        // The byte after a region end starts counting from zero again.
        w_cnt    = r_last ? '0 : r_seen;
        w_sat    = &w_cnt;
        n_seen   = w_sat ? w_cnt : w_cnt + 48'd1;
        // Start offset of a match that ends at this byte, computed from the old count.
        n_a_off  = w_sat ? w_cnt - mbps_pkg::CntW'(w_len) : w_cnt - mbps_pkg::CntW'(w_len_m1);
        n_a_ge   = (w_len != '0) && (w_sat || (w_cnt >= mbps_pkg::CntW'(w_len_m1)));
    end

    assign w_sig.len  = w_len;
    assign w_sig.care = r_care;
    assign w_sig.pat  = {r_pat_high, r_pat_low};

    mbps_match #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_match (
        .i_sig    (w_sig),
        .i_window (r_win),
        .o_match  (w_match)
    );

    assign w_hit      = r_a_vld && r_a_ge && w_match;
    assign w_out_free = !r_out_vld || i_ready;
    assign w_adv      = r_a_vld && (!w_hit || w_out_free);
    assign o_ready    = !r_a_vld || w_adv;
    assign w_acc      = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_care     <= '0;
            r_len      <= 5'd1;
            r_base     <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                mbps_pkg::CfgPatLow:     r_pat_low  <= i_cfg_wdata;
                mbps_pkg::CfgPatHigh:    r_pat_high <= i_cfg_wdata;
                mbps_pkg::CfgCareMask:   r_care     <= i_cfg_wdata[mbps_pkg::MaskW-1:0];
                mbps_pkg::CfgPatLen:     r_len      <= i_cfg_wdata[mbps_pkg::LenW-1:0];
                mbps_pkg::CfgRegionBase: r_base     <= i_cfg_wdata[mbps_pkg::AddrW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_PATTERN; j++) begin
                r_win[j] <= '0;
            end
            r_seen  <= '0;
            r_last  <= 1'b0;
            r_a_vld <= 1'b0;
        end else begin
            if (w_acc) begin
                r_win[0] <= i_data_byte;
                for (int j = 1; j < MAX_PATTERN; j++) begin
                    r_win[j] <= r_win[j-1];
                end
                r_seen  <= n_seen;
                r_last  <= i_region_end;
                r_a_vld <= 1'b1;
            end else if (w_adv) begin
                r_a_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_a_off <= n_a_off;
            r_a_ge  <= n_a_ge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_hit && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hit && w_out_free) begin
            r_out_addr <= r_base + r_a_off;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_hit_address = r_out_addr;

endmodule

>>> hw/rtl/mbps_checker.sv
`include "masked_byte_pattern_scanner_assert.svh"

module mbps_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_cfg_wr_en,
    input logic [mbps_pkg::CfgIdxW-1:0] i_cfg_index,
    input logic [mbps_pkg::PatW-1:0]    i_cfg_wdata,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic [7:0]                   i_data_byte,
    input logic                         i_region_end,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [mbps_pkg::AddrW-1:0]   o_hit_address
);

    // A held hit keeps its address until the transaction completes.
    `MBPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_hit_address))

    // The input side is never blocked while the output register can take a hit.
    `MBPS_ASSERT_IMPL(a_ready_free, i_clk, i_rst_n, !o_valid || i_ready, o_ready)

    // A new hit is presented once the byte that completed it has passed the compare stage and the output register.
    `MBPS_ASSERT_IMPL(a_hit_latency, i_clk, i_rst_n, $rose(o_valid), $past(i_valid && o_ready, 2))

    // Nothing is presented right after reset.
    `MBPS_ASSERT_IMPL(a_reset_idle, i_clk, i_rst_n, $rose(i_rst_n), !o_valid)

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (.*);
